>>> hdl/tdf_pkg.sv
// ----------------------------------------------------------------------------
// tdf_pkg
// Shared types and constants of the trial division factorizer.
// ----------------------------------------------------------------------------
package tdf_pkg;

    // Width of the exponent field of one result pair
    localparam int EXP_WIDTH = 6;

    // Trial division starts at the smallest prime
    localparam int FIRST_DIVISOR = 2;

    typedef logic [EXP_WIDTH-1:0] exponent_t;

    // Status that a serial arithmetic unit reports to its controller
    typedef struct packed {
        logic busy;   // iterating, start is ignored
        logic done;   // one-cycle pulse, results valid from now until next start
    } unit_status_t;

endpackage

>>> hdl/tdf_divider.sv
// ----------------------------------------------------------------------------
// tdf_divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tdf_divider
    import tdf_pkg::*;
#(
    parameter int DIVIDEND_WIDTH = 32,
    parameter int DIVISOR_WIDTH  = 17
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic [DIVIDEND_WIDTH-1:0] dividend,
    input  logic [DIVISOR_WIDTH-1:0]  divisor,
    output unit_status_t              status,
    output logic [DIVIDEND_WIDTH-1:0] quotient,
    output logic [DIVISOR_WIDTH-1:0]  remainder
);

    localparam int CNT_WIDTH = $clog2(DIVIDEND_WIDTH + 1);

    logic [DIVIDEND_WIDTH-1:0] quo_reg;   // dividend bits shift out, quotient bits in
    logic [DIVISOR_WIDTH-1:0]  rem_reg;
    logic [DIVISOR_WIDTH-1:0]  rem_next;
    logic [DIVISOR_WIDTH-1:0]  dvs_reg;
    logic [CNT_WIDTH-1:0]      cnt_reg;
    logic                      busy_reg;
    logic                      done_reg;

    logic [DIVISOR_WIDTH:0] shifted;
    logic [DIVISOR_WIDTH:0] diff;
    logic                   fits;

    always_comb begin
        shifted  = {rem_reg, quo_reg[DIVIDEND_WIDTH-1]};
        diff     = shifted - {1'b0, dvs_reg};
        fits     = shifted >= {1'b0, dvs_reg};
        rem_next = fits ? diff[DIVISOR_WIDTH-1:0] : shifted[DIVISOR_WIDTH-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start && !busy_reg) begin
                quo_reg  <= dividend;
                rem_reg  <= '0;
                dvs_reg  <= divisor;
                cnt_reg  <= CNT_WIDTH'(DIVIDEND_WIDTH);
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                quo_reg <= {quo_reg[DIVIDEND_WIDTH-2:0], fits};
                rem_reg <= rem_next;
                cnt_reg <= cnt_reg - CNT_WIDTH'(1);
                if (cnt_reg == CNT_WIDTH'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign quotient    = quo_reg;
    assign remainder   = rem_reg;

endmodule

>>> hdl/tdf_sqrt.sv
// ----------------------------------------------------------------------------
// tdf_sqrt
// Restoring integer square root, one root bit (two radicand bits) per cycle.
// ----------------------------------------------------------------------------
module tdf_sqrt
    import tdf_pkg::*;
#(
    parameter  int RADICAND_WIDTH = 32,
    localparam int ROOT_WIDTH     = (RADICAND_WIDTH + 1) / 2
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic [RADICAND_WIDTH-1:0] radicand,
    output unit_status_t              status,
    output logic [ROOT_WIDTH-1:0]     root
);

    localparam int PAD_WIDTH = 2 * ROOT_WIDTH;
    localparam int CNT_WIDTH = $clog2(ROOT_WIDTH + 1);

    logic [PAD_WIDTH-1:0]  rad_reg;
    logic [ROOT_WIDTH-1:0] root_reg;
    logic [ROOT_WIDTH:0]   rem_reg;
    logic [ROOT_WIDTH:0]   rem_next;
    logic [CNT_WIDTH-1:0]  cnt_reg;
    logic                  busy_reg;
    logic                  done_reg;

    logic [ROOT_WIDTH+2:0] shifted;
    logic [ROOT_WIDTH+2:0] trial;
    logic [ROOT_WIDTH+2:0] diff;
    logic                  fits;

    always_comb begin
        shifted  = {rem_reg, rad_reg[PAD_WIDTH-1 -: 2]};
        trial    = {1'b0, root_reg, 2'b01};
        diff     = shifted - trial;
        fits     = shifted >= trial;
        rem_next = fits ? diff[ROOT_WIDTH:0] : shifted[ROOT_WIDTH:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start && !busy_reg) begin
                rad_reg  <= PAD_WIDTH'(radicand);
                root_reg <= '0;
                rem_reg  <= '0;
                cnt_reg  <= CNT_WIDTH'(ROOT_WIDTH);
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                rad_reg  <= {rad_reg[PAD_WIDTH-3:0], 2'b00};
                root_reg <= {root_reg[ROOT_WIDTH-2:0], fits};
                rem_reg  <= rem_next;
                cnt_reg  <= cnt_reg - CNT_WIDTH'(1);
                if (cnt_reg == CNT_WIDTH'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign root        = root_reg;

endmodule

>>> hdl/trial_division_factorizer.sv
// ----------------------------------------------------------------------------
// trial_division_factorizer
// Prime factorization by trial division with serial divide and square root.
// ----------------------------------------------------------------------------
//
//  channel  | dir | tdata (low bit up)                  | tlast
//  ---------+-----+-------------------------------------+------------------
//  s_axis   | in  | number                              | -
//  m_axis   | out | prime, exponent                     | last pair of item
//
//  Arithmetic: the root and each trial division run on bit-serial units,
//  the divider giving one quotient bit a cycle. A 32-bit prime takes about
//  65535 trial divisions.
//  Reset: synchronous, active low; clears the controller and both units.
//  Stalls: a held result stalls the search only when the next pair is ready;
//  a new number is taken once the previous one has produced its last pair.
//  Numbers 0 and 1 produce no transfer.
//
module trial_division_factorizer
    import tdf_pkg::*;
#(
    parameter int NUMBER_WIDTH = 32
) (
    input  logic                                       aclk,
    input  logic                                       aresetn,
    input  logic                                       s_axis_tvalid,
    output logic                                       s_axis_tready,
    // [NUMBER_WIDTH-1:0] number, zero padding above
    input  logic [((NUMBER_WIDTH+7)/8)*8-1:0]          s_axis_tdata,
    output logic                                       m_axis_tvalid,
    input  logic                                       m_axis_tready,
    // [NUMBER_WIDTH-1:0] prime, [NUMBER_WIDTH+5:NUMBER_WIDTH] exponent, zeros above
    output logic [((NUMBER_WIDTH+EXP_WIDTH+7)/8)*8-1:0] m_axis_tdata,
    output logic                                       m_axis_tlast
);

    localparam int ROOT_WIDTH = (NUMBER_WIDTH + 1) / 2;
    // trial divisor can reach one past the largest root
    localparam int DIV_WIDTH  = ROOT_WIDTH + 1;
    localparam int OUT_WIDTH  = ((NUMBER_WIDTH + EXP_WIDTH + 7) / 8) * 8;
    localparam int OUT_PAD    = OUT_WIDTH - NUMBER_WIDTH - EXP_WIDTH;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROOT,
        ST_CHECK,
        ST_DIVIDE,
        ST_EMIT
    } state_t;

    state_t                  state_reg;
    logic [NUMBER_WIDTH-1:0] cof_reg;      // remaining cofactor
    logic [DIV_WIDTH-1:0]    trial_reg;    // current trial divisor
    logic [ROOT_WIDTH-1:0]   bound_reg;    // floor root of the cofactor
    exponent_t               mult_reg;     // multiplicity of the current divisor
    logic                    final_reg;    // pending pair is the leftover cofactor
    logic                    sqrt_start_reg;
    logic                    div_start_reg;

    logic                    m_valid_reg;
    logic [NUMBER_WIDTH-1:0] m_prime_reg;
    exponent_t               m_exp_reg;
    logic                    m_last_reg;

    unit_status_t            sqrt_status;
    unit_status_t            div_status;
    logic [ROOT_WIDTH-1:0]   sqrt_root;
    logic [NUMBER_WIDTH-1:0] div_quotient;
    logic [DIV_WIDTH-1:0]    div_remainder;

    logic [NUMBER_WIDTH-1:0] in_number;
    logic                    in_xfer;
    logic                    out_load;

    assign in_number     = s_axis_tdata[NUMBER_WIDTH-1:0];
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    // load the output register once it is empty or being drained
    assign out_load      = (state_reg == ST_EMIT) && (!m_valid_reg || m_axis_tready);

    tdf_sqrt #(
        .RADICAND_WIDTH (NUMBER_WIDTH)
    ) u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (sqrt_start_reg),
        .radicand (cof_reg),
        .status   (sqrt_status),
        .root     (sqrt_root)
    );

    tdf_divider #(
        .DIVIDEND_WIDTH (NUMBER_WIDTH),
        .DIVISOR_WIDTH  (DIV_WIDTH)
    ) u_divider (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start_reg),
        .dividend  (cof_reg),
        .divisor   (trial_reg),
        .status    (div_status),
        .quotient  (div_quotient),
        .remainder (div_remainder)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            cof_reg        <= '0;
            trial_reg      <= '0;
            bound_reg      <= '0;
            mult_reg       <= '0;
            final_reg      <= 1'b0;
            sqrt_start_reg <= 1'b0;
            div_start_reg  <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            sqrt_start_reg <= 1'b0;
            div_start_reg  <= 1'b0;

            // drain the output register; a load below overrides
            if (m_axis_tready) begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (in_xfer) begin
                        cof_reg   <= in_number;
                        trial_reg <= DIV_WIDTH'(FIRST_DIVISOR);
                        mult_reg  <= '0;
                        final_reg <= 1'b0;
                        // zero and one have no factors: drop them
                        if (in_number >= NUMBER_WIDTH'(FIRST_DIVISOR)) begin
                            sqrt_start_reg <= 1'b1;
                            state_reg      <= ST_ROOT;
                        end
                    end
                end

                ST_ROOT: begin
                    if (sqrt_status.done) begin
                        bound_reg <= sqrt_root;
                        state_reg <= ST_CHECK;
                    end
                end

                ST_CHECK: begin
                    if (trial_reg <= {1'b0, bound_reg}) begin
                        div_start_reg <= 1'b1;
                        state_reg     <= ST_DIVIDE;
                    end else if (cof_reg != NUMBER_WIDTH'(1)) begin
                        // leftover cofactor is prime
                        final_reg <= 1'b1;
                        state_reg <= ST_EMIT;
                    end else begin
                        state_reg <= ST_IDLE;
                    end
                end

                ST_DIVIDE: begin
                    if (div_status.done) begin
                        if (div_remainder == '0) begin
                            // divide out once more with the same divisor
                            cof_reg       <= div_quotient;
                            mult_reg      <= mult_reg + EXP_WIDTH'(1);
                            div_start_reg <= 1'b1;
                        end else if (mult_reg != '0) begin
                            state_reg <= ST_EMIT;
                        end else begin
                            trial_reg <= trial_reg + DIV_WIDTH'(1);
                            state_reg <= ST_CHECK;
                        end
                    end
                end

                ST_EMIT: begin
                    if (out_load) begin
                        m_valid_reg <= 1'b1;
                        if (final_reg) begin
                            m_prime_reg <= cof_reg;
                            m_exp_reg   <= EXP_WIDTH'(1);
                            m_last_reg  <= 1'b1;
                            state_reg   <= ST_IDLE;
                        end else begin
                            m_prime_reg <= NUMBER_WIDTH'(trial_reg);
                            m_exp_reg   <= mult_reg;
                            // a fully reduced cofactor leaves nothing to follow
                            m_last_reg  <= (cof_reg == NUMBER_WIDTH'(1));
                            mult_reg       <= '0;
                            trial_reg      <= trial_reg + DIV_WIDTH'(1);
                            sqrt_start_reg <= 1'b1;
                            state_reg      <= ST_ROOT;
                        end
                    end
                end

                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid                                  = m_valid_reg;
    assign m_axis_tlast                                   = m_last_reg;
    assign m_axis_tdata[NUMBER_WIDTH-1:0]                 = m_prime_reg;
    assign m_axis_tdata[NUMBER_WIDTH+EXP_WIDTH-1:NUMBER_WIDTH] = m_exp_reg;

    generate
        if (OUT_PAD > 0) begin : g_out_pad
            assign m_axis_tdata[OUT_WIDTH-1:NUMBER_WIDTH+EXP_WIDTH] = '0;
        end
    endgenerate

    // Both units rest while a new number can be taken
    a_idle_units: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tready |-> !sqrt_status.busy && !div_status.busy)
        else $error("arithmetic unit busy while ready for a new number");

    // A result is never written over one that has not been taken
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_axis_tready |=> m_valid_reg && $stable(m_prime_reg))
        else $error("pending result overwritten");

    // A divide run is only started on an idle divider
    a_div_start: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start_reg |-> !div_status.busy)
        else $error("divider started while busy");

    // The search never uses a divisor below the first prime
    a_trial_floor: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> trial_reg >= DIV_WIDTH'(FIRST_DIVISOR))
        else $error("trial divisor below first prime");

endmodule

>>> tb/tb_trial_division_factorizer.sv
// ----------------------------------------------------------------------------
// tb_trial_division_factorizer
// Self-checking bench for the trial division factorizer. A directed list of
// corner numbers and a set of random numbers are streamed in. Each accepted
// number is factored by a trial-division predictor in the bench. Every
// (prime, exponent, last) pair that comes out is checked against the oldest
// pair still expected. Both channels idle at random.
// ----------------------------------------------------------------------------
module tb_trial_division_factorizer
    import tdf_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUMBER_WIDTH   = 32;
    localparam int S_DATA_WIDTH   = ((NUMBER_WIDTH + 7) / 8) * 8;
    localparam int M_DATA_WIDTH   = ((NUMBER_WIDTH + EXP_WIDTH + 7) / 8) * 8;
    localparam int RESET_CYCLES   = 11;
    localparam int RANDOM_NUMBERS = 80;
    // Cap on trial divisors for random numbers. It bounds the search per
    // number to roughly 400 serial divides.
    localparam int TRIAL_CAP      = 400;
    localparam int WATCHDOG_LIMIT = 200000;
    localparam int DRAIN_CYCLES   = 200;

    // One result pair of the factorization
    typedef struct packed {
        logic [NUMBER_WIDTH-1:0] prime;
        exponent_t               exponent;
        logic                    last;
    } factor_pair_t;

    logic                    aclk;
    logic                    aresetn       = 1'b0;
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    // [31:0] number
    logic [S_DATA_WIDTH-1:0] s_axis_tdata  = '0;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    // [31:0] prime, [37:32] exponent, [39:38] zero
    logic [M_DATA_WIDTH-1:0] m_axis_tdata;
    logic                    m_axis_tlast;

    logic [NUMBER_WIDTH-1:0] numbers_to_send[$];
    factor_pair_t            expected_factors[$];
    int                      mismatch_count = 0;
    int                      idle_cycles    = 0;
    int                      send_gap       = 0;
    int                      ready_hold     = 0;
    int                      phase_cycles   = 0;
    logic                    calm_stretch   = 1'b0;

    trial_division_factorizer #(
        .NUMBER_WIDTH(NUMBER_WIDTH)
    ) dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // Factor one number by trial division. Trial stops once divisor squared
    // exceeds the remaining cofactor, which matches stopping above its exact
    // integer square root. With record set, push the pairs onto the
    // expectation queue; either way return the number of divisors tried, or
    // a value above trial_cap once that cap is crossed.
    function automatic int predict_factors(input logic [NUMBER_WIDTH-1:0] value,
                                           input int trial_cap, input bit record);
        logic [63:0]  rest;
        logic [63:0]  divisor;
        exponent_t    mult;
        int           trials;
        factor_pair_t held;
        bit           have_held;
        rest      = 64'(value);
        divisor   = 64'(FIRST_DIVISOR);
        trials    = 0;
        have_held = 1'b0;
        held      = '0;
        // zero and one have no factorization
        if (rest < 2) return 0;
        while (divisor * divisor <= rest) begin
            trials++;
            if (trials > trial_cap) return trials;
            if (rest % divisor == 0) begin
                mult = '0;
                while (rest % divisor == 0) begin
                    rest = rest / divisor;
                    mult = mult + 1'b1;
                end
                if (record && have_held) expected_factors.push_back(held);
                held.prime    = divisor[NUMBER_WIDTH-1:0];
                held.exponent = mult;
                held.last     = 1'b0;
                have_held     = 1'b1;
            end
            divisor++;
        end
        // whatever is left above one is itself prime
        if (rest != 1) begin
            if (record && have_held) expected_factors.push_back(held);
            held.prime    = rest[NUMBER_WIDTH-1:0];
            held.exponent = exponent_t'(1);
            held.last     = 1'b0;
            have_held     = 1'b1;
        end
        if (record && have_held) begin
            held.last = 1'b1;
            expected_factors.push_back(held);
        end
        return trials;
    endfunction

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 70) return $urandom_range(1, 3);
        if (roll < 95) return $urandom_range(4, 12);
        return $urandom_range(30, 120);
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] seen,
                                   input logic [63:0] wanted);
        mismatch_count++;
        $display("%0t mismatch on %s: got %0d, expected %0d", $realtime, what, seen, wanted);
    endtask

    // Re-roll whether idling is switched off each time the phase counter wraps,
    // so the run holds back-to-back stretches on both channels.
    always @(posedge aclk) begin
        if (phase_cycles == 299) begin
            phase_cycles = 0;
            calm_stretch <= ($urandom_range(0, 3) == 0);
        end else begin
            phase_cycles++;
        end
    end

    // Input driver: advance to the next number once the current transfer is
    // done, honoring a random gap between numbers.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (send_gap > 0) begin
                send_gap--;
                s_axis_tvalid <= 1'b0;
            end else if (numbers_to_send.size() != 0) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= S_DATA_WIDTH'(numbers_to_send.pop_front());
                send_gap = (calm_stretch || $urandom_range(0, 1) == 0) ? 0 : pick_gap();
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Result side back-pressure: drop tready for random stretches, including
    // while a pair is waiting.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
        end else if (ready_hold > 0) begin
            ready_hold--;
            m_axis_tready <= 1'b0;
        end else if (!calm_stretch && $urandom_range(0, 7) == 0) begin
            ready_hold = pick_gap() - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Monitor: check each result transfer against the oldest expectation, then
    // predict the pairs of a number taken in this cycle. Count cycles without
    // any transfer while work is still owed.
    always @(posedge aclk) begin
        factor_pair_t want;
        logic [NUMBER_WIDTH-1:0] got_prime;
        exponent_t               got_exponent;
        if (aresetn) begin
            if (m_axis_tvalid && m_axis_tready) begin
                got_prime    = m_axis_tdata[NUMBER_WIDTH-1:0];
                got_exponent = m_axis_tdata[NUMBER_WIDTH+EXP_WIDTH-1:NUMBER_WIDTH];
                if (expected_factors.size() == 0) begin
                    report_mismatch("pair with nothing expected, prime", 64'(got_prime), 0);
                end else begin
                    want = expected_factors.pop_front();
                    if (got_prime !== want.prime)
                        report_mismatch("prime", 64'(got_prime), 64'(want.prime));
                    if (got_exponent !== want.exponent)
                        report_mismatch("exponent", 64'(got_exponent), 64'(want.exponent));
                    if (m_axis_tlast !== want.last)
                        report_mismatch("tlast", 64'(m_axis_tlast), 64'(want.last));
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                void'(predict_factors(s_axis_tdata[NUMBER_WIDTH-1:0], 32'h7FFF_FFFF, 1'b1));

            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
                idle_cycles = 0;
            end else if (numbers_to_send.size() != 0 || s_axis_tvalid ||
                         expected_factors.size() != 0) begin
                idle_cycles++;
                if (idle_cycles >= WATCHDOG_LIMIT) begin
                    $display("%0t watchdog: no transfer for %0d cycles", $realtime, idle_cycles);
                    $display("tb_trial_division_factorizer NOT OK");
                    $finish;
                end
            end
        end
    end

    initial begin
        logic [63:0]             product;
        logic [NUMBER_WIDTH-1:0] candidate;
        int                      flavor;
        int                      factor;
        int                      random_count;

        // Directed corners: no-result inputs, tiny values, the full-ones and
        // top-bit patterns, alternating bits, the highest exponent, the most
        // distinct primes, primes and prime squares near the root limits.
        numbers_to_send.push_back(32'd0);
        numbers_to_send.push_back(32'd1);
        numbers_to_send.push_back(32'd2);
        numbers_to_send.push_back(32'd3);
        numbers_to_send.push_back(32'd4);
        numbers_to_send.push_back(32'd6);
        numbers_to_send.push_back(32'hFFFF_FFFF);
        numbers_to_send.push_back(32'h8000_0000);
        numbers_to_send.push_back(32'hAAAA_AAAA);
        numbers_to_send.push_back(32'h5555_5555);
        numbers_to_send.push_back(32'd3486784401);  // 3^20
        numbers_to_send.push_back(32'd223092870);   // product of the first nine primes
        numbers_to_send.push_back(32'd65521);       // prime just below 2^16
        numbers_to_send.push_back(32'd65537);       // prime, root exactly 256
        numbers_to_send.push_back(32'd63001);       // 251 squared
        numbers_to_send.push_back(32'd64507);       // 251 * 257
        numbers_to_send.push_back(32'd999983);      // prime, about a thousand trials
        numbers_to_send.push_back(32'd1);
        numbers_to_send.push_back(32'h4000_0000);

        // Random numbers, kept to those that factor within the trial cap so
        // the run stays short. Zero and one are mixed in as noise.
        random_count = 0;
        while (random_count < RANDOM_NUMBERS) begin
            flavor = $urandom_range(0, 99);
            if (flavor < 5) begin
                candidate = NUMBER_WIDTH'($urandom_range(0, 1));
            end else if (flavor < 15) begin
                candidate = NUMBER_WIDTH'($urandom_range(2, 300));
            end else if (flavor < 35) begin
                candidate = $urandom >> $urandom_range(0, 24);
            end else if (flavor < 55) begin
                // power of a small base, up to the width
                factor  = $urandom_range(2, 15);
                product = 64'd1;
                repeat ($urandom_range(1, 31)) begin
                    if (product * factor <= 64'hFFFF_FFFF) product = product * factor;
                end
                candidate = product[NUMBER_WIDTH-1:0];
            end else begin
                // smooth product, sometimes with one larger factor on top
                product = 64'd1;
                repeat ($urandom_range(1, 8)) begin
                    factor = $urandom_range(2, 1 << $urandom_range(2, 8));
                    if (product * factor <= 64'hFFFF_FFFF) product = product * factor;
                end
                if ($urandom_range(0, 1) == 1) begin
                    factor = $urandom_range(257, 65535);
                    if (product * factor <= 64'hFFFF_FFFF) product = product * factor;
                end
                candidate = product[NUMBER_WIDTH-1:0];
            end
            if (predict_factors(candidate, TRIAL_CAP, 1'b0) <= TRIAL_CAP) begin
                numbers_to_send.push_back(candidate);
                if (candidate >= 2) random_count++;
            end
        end

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // Sample at the falling edge, away from the driving edge
        @(negedge aclk);
        while (numbers_to_send.size() != 0 || s_axis_tvalid) @(negedge aclk);
        while (expected_factors.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);

        if (mismatch_count == 0) begin
            $display("tb_trial_division_factorizer OK");
        end else begin
            $display("tb_trial_division_factorizer NOT OK");
        end
        $finish;
    end

endmodule

>>> filelist.f
hdl/tdf_pkg.sv
hdl/tdf_divider.sv
hdl/tdf_sqrt.sv
hdl/trial_division_factorizer.sv
tb/tb_trial_division_factorizer.sv
